>>> rtl/keyed_entry_table_defines.svh
// ----------------------------------------------------------------------------
// Keyed entry table assertion macros
// Shared assertion macros for the keyed entry table RTL, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_ENTRY_TABLE_DEFINES_SVH
`define KEYED_ENTRY_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

`define KET_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define KET_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KET_ASSERT_IMP(label, ante, cons, msg)

`define KET_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/ket_pkg.sv
// ----------------------------------------------------------------------------
// Keyed entry table package
// Command, status and state codes, the key type and the cell control word.
// ----------------------------------------------------------------------------
package ket_pkg;

    typedef logic signed [31:0] key_t;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_ADD_DUP   = 3'd2,
        ST_DEL_MISS  = 3'd3,
        ST_UPD_CLASH = 3'd4,
        ST_UPD_MISS  = 3'd5,
        ST_GET_MISS  = 3'd6
    } status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } state_t;

    typedef struct packed {
        logic cmp_en;
        logic wr_en;
        logic shift_en;
    } cell_ctrl_t;

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [4:0] CAPACITY_RESET = 5'd16;

endpackage

>>> rtl/ket_req_if.sv
// ----------------------------------------------------------------------------
// Keyed entry table request channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface ket_req_if;

    logic           valid;
    logic           ready;
    logic [2:0]     cmd;
    ket_pkg::key_t  key;
    ket_pkg::key_t  new_key;
    logic [63:0]    entry_value;

    modport source (output valid, output cmd, output key, output new_key,
                    output entry_value, input ready);
    modport sink (input valid, input cmd, input key, input new_key,
                  input entry_value, output ready);

endinterface

>>> rtl/ket_rsp_if.sv
// ----------------------------------------------------------------------------
// Keyed entry table response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface ket_rsp_if;

    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] found_value;
    logic [4:0]  entry_count;

    modport source (output valid, output status, output found_value,
                    output entry_count, input ready);
    modport sink (input valid, input status, input found_value,
                  input entry_count, output ready);

endinterface

>>> rtl/keyed_entry_table.sv
// ----------------------------------------------------------------------------
// Keyed entry table
// Ordered key/value table built as a row of entry cells with unique keys.
// ----------------------------------------------------------------------------
// A command word is accepted in S_IDLE and applied in S_APPLY. At the edge
// that accepts it every cell compares its key with key and new_key; at the
// apply edge the table writes at most one cell, shifts the cells above a
// deleted entry down by one place, and loads the result word into the output
// register. The next word is accepted after the apply edge, so the table
// takes no new word before it is through with the last one; a result still
// held on the response side delays only the apply edge of the next command.
`include "keyed_entry_table_defines.svh"

module keyed_entry_table
#(
    parameter int TABLE_DEPTH = 16,
    parameter int NAME_BYTES  = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    ket_req_if.sink                        request,
    ket_rsp_if.source                      response,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ket_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int VALUE_W = 8 * NAME_BYTES;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    ket_pkg::state_t     state_reg;
    ket_pkg::state_t     state_next;
    ket_pkg::cmd_t       cmd_reg;
    ket_pkg::key_t       key_reg;
    ket_pkg::key_t       new_key_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                out_valid_reg;
    ket_pkg::status_t    out_status_reg;
    logic [VALUE_W-1:0]  out_found_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic [4:0]          capacity_limit;
    logic [CNT_W-1:0]    limit;
    logic                accept;
    logic                out_free;
    logic                apply_go;

    ket_pkg::key_t       cell_key   [TABLE_DEPTH];
    logic [VALUE_W-1:0]  cell_value [TABLE_DEPTH];
    ket_pkg::cell_ctrl_t cell_ctrl  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_key_raw;
    logic [TABLE_DEPTH-1:0] match_new_raw;
    logic [TABLE_DEPTH-1:0] hit_key;
    logic [TABLE_DEPTH-1:0] hit_new;

    logic [IDX_W-1:0]    pos_key;
    logic [VALUE_W-1:0]  found_value;
    ket_pkg::status_t    status_next;
    logic [VALUE_W-1:0]  found_next;
    logic                wr_at_count;
    logic                wr_at_hit;
    logic                do_shift;
    ket_pkg::key_t       wr_key;

    ket_cfg u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .capacity_limit (capacity_limit)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ket_pkg::S_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = ket_pkg::S_APPLY;
                end
            end
            ket_pkg::S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = ket_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ket_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_free      = !out_valid_reg || response.ready;
        request.ready = (state_reg == ket_pkg::S_IDLE);
        accept        = request.valid && request.ready;
        apply_go      = (state_reg == ket_pkg::S_APPLY) && out_free;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= ket_pkg::cmd_t'(request.cmd);
            key_reg     <= request.key;
            new_key_reg <= request.new_key;
            value_reg   <= request.entry_value[VALUE_W-1:0];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            ket_pkg::key_t      nb_key;
            logic [VALUE_W-1:0] nb_value;

            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign nb_key   = '0;
                assign nb_value = '0;
            end
            else
            begin : g_mid
                assign nb_key   = cell_key[gi + 1];
                assign nb_value = cell_value[gi + 1];
            end

            assign hit_key[gi] = match_key_raw[gi] && (CNT_W'(gi) < count_reg);
            assign hit_new[gi] = match_new_raw[gi] && (CNT_W'(gi) < count_reg);

            assign cell_ctrl[gi].cmp_en   = accept;
            assign cell_ctrl[gi].wr_en    = apply_go &&
                ((wr_at_count && (count_reg == CNT_W'(gi))) || (wr_at_hit && hit_key[gi]));
            assign cell_ctrl[gi].shift_en = apply_go && do_shift && (IDX_W'(gi) >= pos_key);

            ket_cell #(.VALUE_W(VALUE_W)) u_cell
            (
                .clk         (clk),
                .ctrl        (cell_ctrl[gi]),
                .cmp_key     (request.key),
                .cmp_new_key (request.new_key),
                .wr_key      (wr_key),
                .wr_value    (value_reg),
                .next_key    (nb_key),
                .next_value  (nb_value),
                .key_out     (cell_key[gi]),
                .value_out   (cell_value[gi]),
                .match_key   (match_key_raw[gi]),
                .match_new   (match_new_raw[gi])
            );
        end
    endgenerate

    // Keys are unique among held entries, so at most one cell hits and the
    // hit vector can be encoded and muxed by plain OR.
    always_comb
    begin
        pos_key     = '0;
        found_value = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (hit_key[i])
            begin
                pos_key     = pos_key | IDX_W'(i);
                found_value = found_value | cell_value[i];
            end
        end
    end

    always_comb
    begin
        if (int'(capacity_limit) >= TABLE_DEPTH)
        begin
            limit = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            limit = CNT_W'(capacity_limit);
        end
    end

    always_comb
    begin
        status_next = ket_pkg::ST_OK;
        found_next  = '0;
        count_next  = count_reg;
        wr_at_count = 1'b0;
        wr_at_hit   = 1'b0;
        do_shift    = 1'b0;
        wr_key      = (cmd_reg == ket_pkg::CMD_ADD) ? key_reg : new_key_reg;
        unique case (cmd_reg)
            ket_pkg::CMD_ADD:
            begin
                priority if (count_reg >= limit)
                begin
                    status_next = ket_pkg::ST_FULL;
                end
                else if (|hit_key)
                begin
                    status_next = ket_pkg::ST_ADD_DUP;
                end
                else
                begin
                    wr_at_count = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            ket_pkg::CMD_DELETE:
            begin
                if (|hit_key)
                begin
                    do_shift   = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ket_pkg::ST_DEL_MISS;
                end
            end
            ket_pkg::CMD_UPDATE:
            begin
                priority if ((key_reg != new_key_reg) && (|hit_new))
                begin
                    status_next = ket_pkg::ST_UPD_CLASH;
                end
                else if (!(|hit_key))
                begin
                    status_next = ket_pkg::ST_UPD_MISS;
                end
                else
                begin
                    wr_at_hit = 1'b1;
                end
            end
            ket_pkg::CMD_GET:
            begin
                if (|hit_key)
                begin
                    found_next = found_value;
                end
                else
                begin
                    status_next = ket_pkg::ST_GET_MISS;
                end
            end
            ket_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = ket_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ket_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_go)
        begin
            out_status_reg <= status_next;
            out_found_reg  <= found_next;
            out_count_reg  <= count_next;
        end
    end

    assign response.valid       = out_valid_reg;
    assign response.status      = out_status_reg;
    assign response.found_value = 64'(out_found_reg);
    assign response.entry_count = 5'(out_count_reg);

    `KET_ASSERT_IMP(a_count_in_range, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "count above depth")
    `KET_ASSERT_IMP(a_unique_keys, state_reg == ket_pkg::S_APPLY, $onehot0(hit_key), "key held twice")
    `KET_ASSERT_NXT(a_add_grows, apply_go && wr_at_count, count_reg == $past(count_reg) + 1'b1, "add lost")
    `KET_ASSERT_IMP(a_found_only_ok, response.valid && response.status != ket_pkg::ST_OK, response.found_value == 64'd0, "stray value")

endmodule

>>> rtl/ket_cfg.sv
// ----------------------------------------------------------------------------
// Keyed entry table configuration registers
// APB-style register port holding the capacity limit.
// ----------------------------------------------------------------------------
module ket_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ket_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [4:0]                     capacity_limit
);

    logic [4:0] capacity_reg;
    logic [4:0] capacity_next;
    logic       sel_capacity;

    assign pready       = 1'b1;
    assign sel_capacity = (paddr[2] == ket_pkg::REG_CAPACITY);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && pready && sel_capacity)
        begin
            capacity_next = pwdata[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= ket_pkg::CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign prdata         = sel_capacity ? 32'(capacity_reg) : 32'd0;
    assign capacity_limit = capacity_reg;

endmodule

>>> rtl/ket_cell.sv
// ----------------------------------------------------------------------------
// Keyed entry table cell
// One table entry: compares its key on acceptance, is written in place, or
// takes the entry of its right-hand neighbor when the table closes a gap.
// ----------------------------------------------------------------------------
module ket_cell
#(
    parameter int VALUE_W = 64
)
(
    input  logic                 clk,
    input  ket_pkg::cell_ctrl_t  ctrl,
    input  ket_pkg::key_t        cmp_key,
    input  ket_pkg::key_t        cmp_new_key,
    input  ket_pkg::key_t        wr_key,
    input  logic [VALUE_W-1:0]   wr_value,
    input  ket_pkg::key_t        next_key,
    input  logic [VALUE_W-1:0]   next_value,
    output ket_pkg::key_t        key_out,
    output logic [VALUE_W-1:0]   value_out,
    output logic                 match_key,
    output logic                 match_new
);

    ket_pkg::key_t      key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               match_key_reg;
    logic               match_new_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            match_key_reg <= (key_reg == cmp_key);
            match_new_reg <= (key_reg == cmp_new_key);
        end
        if (ctrl.wr_en)
        begin
            key_reg   <= wr_key;
            value_reg <= wr_value;
        end
        else if (ctrl.shift_en)
        begin
            key_reg   <= next_key;
            value_reg <= next_value;
        end
    end

    assign key_out   = key_reg;
    assign value_out = value_reg;
    assign match_key = match_key_reg;
    assign match_new = match_new_reg;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Keyed entry table testbench
// Sends add, delete, update, get, clear and unknown command words through
// the request channel and checks every result word against a shadow copy of
// the table kept here. Directed cases cover empty-table misses, key and value
// extremes, duplicates, clashes and the capacity limit. Random phases then run
// at several capacity settings, with random gaps on both channels, one burst
// with no gaps, one long response stall and twelve drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int VALUE_BYTES = 8;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - 8 * VALUE_BYTES);
    localparam logic [ket_pkg::CFG_ADDR_W-1:0] CAPACITY_ADDR =
        ket_pkg::CFG_ADDR_W'(4 * ket_pkg::REG_CAPACITY);
    localparam ket_pkg::key_t KEY_MIN = 32'h8000_0000;
    localparam ket_pkg::key_t KEY_MAX = 32'h7FFF_FFFF;
    localparam int POOL_SIZE = 24;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        ket_pkg::status_t status;
        logic [63:0]      found_value;
        logic [4:0]       entry_count;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ket_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    logic gaps_on = 1'b1;
    logic rx_hold = 1'b0;
    int error_count = 0;
    int idle_cycles = 0;

    ket_pkg::key_t shadow_keys [DEPTH];
    logic [63:0]   shadow_values [DEPTH];
    int            shadow_count = 0;
    int            shadow_capacity = ket_pkg::CAPACITY_RESET;
    ket_pkg::key_t key_pool [POOL_SIZE];

    table_result_t pending_results [$];

    ket_req_if cmd_ch ();
    ket_rsp_if result_ch ();

    keyed_entry_table #(
        .TABLE_DEPTH (DEPTH),
        .NAME_BYTES  (VALUE_BYTES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (cmd_ch),
        .response (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int find_entry(ket_pkg::key_t key);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_keys[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic table_result_t table_apply(logic [2:0] cmd, ket_pkg::key_t key,
                                                  ket_pkg::key_t new_key,
                                                  logic [63:0] value);
        table_result_t res;
        int pos;
        int limit;
        res.status = ket_pkg::ST_OK;
        res.found_value = '0;
        limit = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
        case (cmd)
            ket_pkg::CMD_ADD:
            begin
                if (shadow_count + 1 > limit || shadow_count >= DEPTH)
                    res.status = ket_pkg::ST_FULL;
                else if (find_entry(key) >= 0)
                    res.status = ket_pkg::ST_ADD_DUP;
                else
                begin
                    shadow_keys[shadow_count] = key;
                    shadow_values[shadow_count] = value & VALUE_MASK;
                    shadow_count++;
                end
            end
            ket_pkg::CMD_DELETE:
            begin
                pos = find_entry(key);
                if (pos < 0)
                    res.status = ket_pkg::ST_DEL_MISS;
                else
                begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i] = shadow_keys[i + 1];
                        shadow_values[i] = shadow_values[i + 1];
                    end
                    shadow_count--;
                end
            end
            ket_pkg::CMD_UPDATE:
            begin
                if (key != new_key && find_entry(new_key) >= 0)
                    res.status = ket_pkg::ST_UPD_CLASH;
                else
                begin
                    pos = find_entry(key);
                    if (pos < 0)
                        res.status = ket_pkg::ST_UPD_MISS;
                    else
                    begin
                        shadow_keys[pos] = new_key;
                        shadow_values[pos] = value & VALUE_MASK;
                    end
                end
            end
            ket_pkg::CMD_GET:
            begin
                pos = find_entry(key);
                if (pos < 0)
                    res.status = ket_pkg::ST_GET_MISS;
                else
                    res.found_value = shadow_values[pos];
            end
            ket_pkg::CMD_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        res.entry_count = 5'(shadow_count);
        return res;
    endfunction

    task automatic send_word(logic [2:0] cmd, ket_pkg::key_t key, ket_pkg::key_t new_key,
                             logic [63:0] value);
        while (gaps_on && $urandom_range(99) < 21)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= cmd;
        cmd_ch.key <= key;
        cmd_ch.new_key <= new_key;
        cmd_ch.entry_value <= value;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pending_results.push_back(table_apply(cmd, key, new_key, value));
    endtask

    task automatic send_random_word();
        logic [2:0] cmd;
        ket_pkg::key_t key;
        ket_pkg::key_t new_key;
        logic [63:0] value;
        int pick;
        pick = $urandom_range(99);
        if (pick < 36)
            cmd = ket_pkg::CMD_ADD;
        else if (pick < 56)
            cmd = ket_pkg::CMD_DELETE;
        else if (pick < 72)
            cmd = ket_pkg::CMD_UPDATE;
        else if (pick < 92)
            cmd = ket_pkg::CMD_GET;
        else if (pick < 95)
            cmd = ket_pkg::CMD_CLEAR;
        else
            cmd = 3'($urandom_range(7, 5));
        if ($urandom_range(99) < 88)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            key = ket_pkg::key_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 30)
            new_key = key;
        else if (pick < 80)
            new_key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            new_key = ket_pkg::key_t'($urandom);
        pick = $urandom_range(9);
        if (pick == 0)
            value = '0;
        else if (pick == 1)
            value = '1;
        else
            value = {$urandom, $urandom};
        send_word(cmd, key, new_key, value);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAPACITY_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        shadow_capacity = value & 32'h1F;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_empty_table();
        send_word(ket_pkg::CMD_GET, KEY_MIN, '0, '0);
        send_word(ket_pkg::CMD_DELETE, 32'sd5, '0, '1);
        send_word(ket_pkg::CMD_UPDATE, 32'sd5, 32'sd6, 64'h1234);
        send_word(ket_pkg::CMD_CLEAR, KEY_MAX, KEY_MAX, '1);
        send_word(3'd5, 32'sd1, 32'sd2, '1);
        send_word(3'd6, KEY_MIN, KEY_MAX, 64'h5555_5555_5555_5555);
        send_word(3'd7, '1, '1, '1);
    endtask

    task automatic test_basic_ops();
        send_word(ket_pkg::CMD_ADD, KEY_MIN, '0, '0);
        send_word(ket_pkg::CMD_ADD, KEY_MAX, '0, '1);
        send_word(ket_pkg::CMD_ADD, 32'sd0, '0, 64'h0123_4567_89AB_CDEF);
        send_word(ket_pkg::CMD_ADD, KEY_MAX, '0, 64'hAAAA);
        send_word(ket_pkg::CMD_GET, KEY_MAX, '0, '0);
        send_word(ket_pkg::CMD_UPDATE, 32'sd0, 32'sd0, 64'hFEDC_BA98_7654_3210);
        send_word(ket_pkg::CMD_UPDATE, KEY_MIN, KEY_MAX, 64'h1);
        send_word(ket_pkg::CMD_UPDATE, KEY_MIN, -32'sd1, 64'h8000_0000_0000_0001);
        send_word(ket_pkg::CMD_GET, -32'sd1, '0, '0);
        send_word(ket_pkg::CMD_DELETE, KEY_MAX, '0, '0);
        send_word(ket_pkg::CMD_GET, 32'sd0, '0, '0);
        send_word(ket_pkg::CMD_DELETE, KEY_MAX, '0, '0);
    endtask

    task automatic test_capacity_edges();
        send_word(ket_pkg::CMD_CLEAR, '0, '0, '0);
        wait_drained();
        write_capacity(2);
        send_word(ket_pkg::CMD_ADD, 32'sd1, '0, 64'h11);
        send_word(ket_pkg::CMD_ADD, 32'sd2, '0, 64'h22);
        send_word(ket_pkg::CMD_ADD, 32'sd3, '0, 64'h33);
        send_word(ket_pkg::CMD_ADD, 32'sd1, '0, 64'h44);
        wait_drained();
        write_capacity(1);
        send_word(ket_pkg::CMD_ADD, 32'sd4, '0, 64'h55);
        send_word(ket_pkg::CMD_GET, 32'sd2, '0, '0);
        send_word(ket_pkg::CMD_UPDATE, 32'sd2, 32'sd5, 64'h66);
        send_word(ket_pkg::CMD_DELETE, 32'sd1, '0, '0);
        wait_drained();
        write_capacity(0);
        send_word(ket_pkg::CMD_CLEAR, '0, '0, '0);
        send_word(ket_pkg::CMD_ADD, 32'sd7, '0, 64'h77);
        wait_drained();
        write_capacity(31);
        for (int i = 0; i <= DEPTH; i++)
            send_word(ket_pkg::CMD_ADD, ket_pkg::key_t'(i * 32'h1111_1111), '0,
                      {$urandom, $urandom});
        send_word(ket_pkg::CMD_CLEAR, '0, '0, '0);
    endtask

    task automatic test_random_phases();
        int unsigned caps [7] = '{16, 31, 5, 0, 8, 1, 16};
        int counts [7] = '{200, 200, 150, 40, 150, 100, 200};
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = ket_pkg::key_t'($urandom);
        for (int p = 0; p < 7; p++)
        begin
            wait_drained();
            write_capacity(caps[p]);
            repeat (counts[p])
                send_random_word();
        end
    endtask

    task automatic test_burst_no_gaps();
        gaps_on <= 1'b0;
        repeat (350)
            send_random_word();
        gaps_on <= 1'b1;
    endtask

    task automatic test_output_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (60)
            send_random_word();
    endtask

    task automatic test_drain_pauses();
        repeat (12)
        begin
            repeat (5)
                send_random_word();
            wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        if (rx_hold)
            result_ch.ready <= 1'b0;
        else if (gaps_on)
            result_ch.ready <= ($urandom_range(99) >= 21);
        else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        table_result_t exp_res;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word: status %0d value %h count %0d",
                         $realtime, result_ch.status, result_ch.found_value,
                         result_ch.entry_count);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (result_ch.status !== exp_res.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $realtime, exp_res.status, result_ch.status);
                    error_count++;
                end
                if (result_ch.found_value !== exp_res.found_value)
                begin
                    $display("%0t: found_value mismatch: expected %h, actual %h",
                             $realtime, exp_res.found_value, result_ch.found_value);
                    error_count++;
                end
                if (result_ch.entry_count !== exp_res.entry_count)
                begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $realtime, exp_res.entry_count, result_ch.entry_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[keyed_entry_table] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = '0;
        cmd_ch.key = '0;
        cmd_ch.new_key = '0;
        cmd_ch.entry_value = '0;
        result_ch.ready = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_basic_ops();
        test_capacity_edges();
        test_random_phases();
        test_burst_no_gaps();
        test_output_backpressure();
        test_drain_pauses();
        wait_drained();
        repeat (20)
            @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[keyed_entry_table] OK");
        else
            $display("[keyed_entry_table] ERROR");
        $finish;
    end

endmodule
